FILE: hdl/lom_pkg.sv
`timescale 1ns / 1ps
// Shared types and codes of the limit order matcher.
package lom_pkg;

  localparam int unsigned PRICE_W          = 20;
  localparam int unsigned QTY_W            = 20;
  localparam int unsigned KIND_W           = 3;
  localparam int unsigned BOOK_DEPTH_DEF   = 32;

  localparam logic [QTY_W-1:0] QTY_MAX = {QTY_W{1'b1}};

  localparam logic [KIND_W-1:0] KIND_FILL   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_FILLED = 3'd1;
  localparam logic [KIND_W-1:0] KIND_RESTED = 3'd2;
  localparam logic [KIND_W-1:0] KIND_MERGED = 3'd3;
  localparam logic [KIND_W-1:0] KIND_FULL   = 3'd4;

  typedef struct packed {
    logic               side_is_buy;
    logic [QTY_W-1:0]   order_qty;
    logic [PRICE_W-1:0] order_price;
  } order_t;

  typedef struct packed {
    logic [KIND_W-1:0]  report_kind;
    logic [PRICE_W-1:0] trade_price;
    logic [QTY_W-1:0]   trade_qty;
    logic [QTY_W-1:0]   rest_qty;
    logic               last_report;
  } report_t;

  typedef struct packed {
    logic               is_buy;
    logic [PRICE_W-1:0] price;
    logic [QTY_W-1:0]   qty;
  } level_t;

  typedef struct packed {
    logic done;
    logic hit;
    logic same;
    logic free;
  } scan_flags_t;

endpackage

FILE: hdl/lom_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module lom_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/lom_scan.sv
`timescale 1ns / 1ps
// Book sweep: reads every entry once and keeps best cross, same level and free slot.
module lom_scan #(
  parameter int unsigned BOOK_DEPTH = lom_pkg::BOOK_DEPTH_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic                             buy_i,
  input  logic [lom_pkg::PRICE_W-1:0]      price_i,
  input  logic [BOOK_DEPTH-1:0]            valid_i,
  output logic [$clog2(BOOK_DEPTH)-1:0]    raddr_o,
  input  lom_pkg::level_t                  rdata_i,
  output lom_pkg::scan_flags_t             flags_o,
  output logic [$clog2(BOOK_DEPTH)-1:0]    hit_idx_o,
  output logic [lom_pkg::PRICE_W-1:0]      hit_price_o,
  output logic [lom_pkg::QTY_W-1:0]        hit_qty_o,
  output logic [$clog2(BOOK_DEPTH)-1:0]    same_idx_o,
  output logic [lom_pkg::QTY_W-1:0]        same_qty_o,
  output logic [$clog2(BOOK_DEPTH)-1:0]    free_idx_o
);
  import lom_pkg::*;

  localparam int unsigned IdxW = $clog2(BOOK_DEPTH);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(BOOK_DEPTH - 1);

  logic            busy_q, busy_d;
  logic [IdxW-1:0] rd_cnt_q, rd_cnt_d;
  logic            rv_q;
  logic [IdxW-1:0] ridx_q;

  scan_flags_t        flags_q, flags_d;
  logic [PRICE_W-1:0] best_q, best_d;
  logic [IdxW-1:0]    hit_idx_q, hit_idx_d;
  logic [QTY_W-1:0]   hit_qty_q, hit_qty_d;
  logic [IdxW-1:0]    same_idx_q, same_idx_d;
  logic [QTY_W-1:0]   same_qty_q, same_qty_d;
  logic [IdxW-1:0]    free_idx_q, free_idx_d;

  logic               ent_valid, ent_cross, ent_same, ent_free;
  logic [PRICE_W-1:0] bound;

  assign bound     = flags_q.hit ? best_q : price_i;
  assign ent_valid = valid_i[ridx_q];
  assign ent_cross = ent_valid && (rdata_i.is_buy != buy_i) &&
                     (buy_i ? (rdata_i.price <= bound) : (rdata_i.price >= bound));
  assign ent_same  = ent_valid && (rdata_i.is_buy == buy_i) &&
                     (rdata_i.price == price_i) && !flags_q.same;
  assign ent_free  = !ent_valid && !flags_q.free;

  always_comb begin
    busy_d     = busy_q;
    rd_cnt_d   = rd_cnt_q;
    flags_d    = flags_q;
    best_d     = best_q;
    hit_idx_d  = hit_idx_q;
    hit_qty_d  = hit_qty_q;
    same_idx_d = same_idx_q;
    same_qty_d = same_qty_q;
    free_idx_d = free_idx_q;
    flags_d.done = 1'b0;
    if (start_i) begin
      busy_d   = 1'b1;
      rd_cnt_d = '0;
      flags_d  = '0;
    end else begin
      if (busy_q) begin
        if (rd_cnt_q == LastIdx) begin
          busy_d = 1'b0;
        end else begin
          rd_cnt_d = rd_cnt_q + 1'b1;
        end
      end
      if (rv_q) begin
        if (ent_cross) begin
          flags_d.hit = 1'b1;
          best_d      = rdata_i.price;
          hit_idx_d   = ridx_q;
          hit_qty_d   = rdata_i.qty;
        end
        if (ent_same) begin
          flags_d.same = 1'b1;
          same_idx_d   = ridx_q;
          same_qty_d   = rdata_i.qty;
        end
        if (ent_free) begin
          flags_d.free = 1'b1;
          free_idx_d   = ridx_q;
        end
        flags_d.done = (ridx_q == LastIdx);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      rv_q    <= 1'b0;
      flags_q <= '0;
    end else begin
      busy_q  <= busy_d;
      rv_q    <= busy_q && !start_i;
      flags_q <= flags_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_cnt_q   <= rd_cnt_d;
    ridx_q     <= rd_cnt_q;
    best_q     <= best_d;
    hit_idx_q  <= hit_idx_d;
    hit_qty_q  <= hit_qty_d;
    same_idx_q <= same_idx_d;
    same_qty_q <= same_qty_d;
    free_idx_q <= free_idx_d;
  end

  assign raddr_o     = rd_cnt_q;
  assign flags_o     = flags_q;
  assign hit_idx_o   = hit_idx_q;
  assign hit_price_o = best_q;
  assign hit_qty_o   = hit_qty_q;
  assign same_idx_o  = same_idx_q;
  assign same_qty_o  = same_qty_q;
  assign free_idx_o  = free_idx_q;

endmodule

FILE: hdl/limit_order_matcher.sv
`timescale 1ns / 1ps
// Top level of the limit order matcher: sequencer, valid bits, book RAM and report register.
//
//   channel   direction  handshake                payload
//   in        request in  in_valid_i / in_ready_o  in_req_i  (order_t)
//   out       report out  out_valid_o / out_ready_i out_rep_o (report_t)
//
// A zero-quantity order goes straight to its final report. Otherwise each pass over the book
// reads every entry through the single RAM read port. An order with F fills that rests,
// merges or drops runs F + 1 passes; a fully filled one runs F passes.
// Reset clears the valid bits at once: the book is empty and no clearing pass runs.
// A new request is taken once the previous one has queued its final report.
// A report waiting on out_ready_i holds the sequencer before its next book update.
module limit_order_matcher #(
  parameter int unsigned BOOK_DEPTH = lom_pkg::BOOK_DEPTH_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  lom_pkg::order_t  in_req_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output lom_pkg::report_t out_rep_o
);
  import lom_pkg::*;

  localparam int unsigned IdxW = $clog2(BOOK_DEPTH);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_DECIDE = 2'd2;
  localparam logic [1:0] ST_DONE   = 2'd3;

  logic [1:0]            state_q, state_d;
  logic                  buy_q, buy_d;
  logic [QTY_W-1:0]      rem_q, rem_d;
  logic [PRICE_W-1:0]    price_q, price_d;
  logic [BOOK_DEPTH-1:0] valid_q, valid_d;
  logic                  out_valid_q, out_valid_d;
  report_t               out_rep_q, out_rep_d;

  logic                  scan_start;
  scan_flags_t           flags;
  logic [IdxW-1:0]       raddr, hit_idx, same_idx, free_idx;
  logic [PRICE_W-1:0]    hit_price;
  logic [QTY_W-1:0]      hit_qty, same_qty;
  level_t                rdata;

  logic                  ram_we;
  logic [IdxW-1:0]       ram_waddr;
  level_t                ram_wdata;

  logic                  slot_free;
  logic [QTY_W-1:0]      fill, left, rem_after;
  logic [QTY_W:0]        sum;
  logic [QTY_W-1:0]      merged;

  assign slot_free = !out_valid_q || out_ready_i;
  assign fill      = (rem_q < hit_qty) ? rem_q : hit_qty;
  assign left      = hit_qty - fill;
  assign rem_after = rem_q - fill;
  assign sum       = {1'b0, same_qty} + {1'b0, rem_q};
  assign merged    = sum[QTY_W] ? QTY_MAX : sum[QTY_W-1:0];

  always_comb begin
    state_d     = state_q;
    buy_d       = buy_q;
    rem_d       = rem_q;
    price_d     = price_q;
    valid_d     = valid_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_rep_d   = out_rep_q;
    scan_start  = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = hit_idx;
    ram_wdata   = '{is_buy: !buy_q, price: hit_price, qty: left};
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          buy_d   = in_req_i.side_is_buy;
          rem_d   = in_req_i.order_qty;
          price_d = in_req_i.order_price;
          if (in_req_i.order_qty == '0) begin
            state_d = ST_DONE;
          end else begin
            scan_start = 1'b1;
            state_d    = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (flags.done) begin
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_rep_d   = '0;
          if (flags.hit) begin
            ram_we = 1'b1;
            if (left == '0) begin
              valid_d[hit_idx] = 1'b0;
            end
            rem_d                 = rem_after;
            out_rep_d.report_kind = KIND_FILL;
            out_rep_d.trade_price = hit_price;
            out_rep_d.trade_qty   = fill;
            out_rep_d.rest_qty    = rem_after;
            if (rem_after == '0) begin
              state_d = ST_DONE;
            end else begin
              scan_start = 1'b1;
              state_d    = ST_SCAN;
            end
          end else begin
            out_rep_d.rest_qty    = rem_q;
            out_rep_d.last_report = 1'b1;
            state_d               = ST_IDLE;
            if (flags.same) begin
              ram_we                = 1'b1;
              ram_waddr             = same_idx;
              ram_wdata             = '{is_buy: buy_q, price: price_q, qty: merged};
              out_rep_d.report_kind = KIND_MERGED;
            end else if (flags.free) begin
              ram_we                = 1'b1;
              ram_waddr             = free_idx;
              ram_wdata             = '{is_buy: buy_q, price: price_q, qty: rem_q};
              valid_d[free_idx]     = 1'b1;
              out_rep_d.report_kind = KIND_RESTED;
            end else begin
              out_rep_d.report_kind = KIND_FULL;
            end
          end
        end
      end
      ST_DONE: begin
        if (slot_free) begin
          out_valid_d           = 1'b1;
          out_rep_d             = '0;
          out_rep_d.report_kind = KIND_FILLED;
          out_rep_d.last_report = 1'b1;
          state_d               = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      valid_q     <= valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    buy_q     <= buy_d;
    rem_q     <= rem_d;
    price_q   <= price_d;
    out_rep_q <= out_rep_d;
  end

  lom_ram #(
    .WIDTH ($bits(level_t)),
    .DEPTH (BOOK_DEPTH)
  ) u_book (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  lom_scan #(
    .BOOK_DEPTH (BOOK_DEPTH)
  ) u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (scan_start),
    .buy_i       (buy_q),
    .price_i     (price_q),
    .valid_i     (valid_q),
    .raddr_o     (raddr),
    .rdata_i     (rdata),
    .flags_o     (flags),
    .hit_idx_o   (hit_idx),
    .hit_price_o (hit_price),
    .hit_qty_o   (hit_qty),
    .same_idx_o  (same_idx),
    .same_qty_o  (same_qty),
    .free_idx_o  (free_idx)
  );

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_rep_o   = out_rep_q;

endmodule

FILE: hdl/lom_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the limit order matcher, bound to the top level.
module lom_checker (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_o,
  input logic             out_valid_o,
  input logic             out_ready_i,
  input lom_pkg::report_t out_rep_o
);
  import lom_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_rep_o))
    else $error("report changed while stalled");

  a_last_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((out_rep_o.report_kind == KIND_FILL) == !out_rep_o.last_report))
    else $error("last_report does not match report kind");

  a_fill_qty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_rep_o.report_kind == KIND_FILL) |-> (out_rep_o.trade_qty != '0))
    else $error("fill report with zero quantity");

  a_final_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rep_o.last_report |->
      (out_rep_o.trade_qty == '0) && (out_rep_o.trade_price == '0))
    else $error("final report carries trade fields");

  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request taken while previous one still at work");

endmodule

bind limit_order_matcher lom_checker u_lom_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_rep_o   (out_rep_o)
);
